### sv/ppp_pkg.sv
// Package for the parallel printer port core.
// Holds the word types, register offsets, status and control bit masks.
// No dependencies.
`default_nettype none

package ppp_pkg;

  typedef struct packed {
    logic       cmd;
    logic [2:0] reg_offset;
    logic [7:0] write_data;
  } ppp_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       printer_byte_valid;
    logic [7:0] printer_byte;
    logic       irq_line;
  } ppp_out_t;

  localparam logic       CMD_READ  = 1'b0;
  localparam logic       CMD_WRITE = 1'b1;

  localparam logic [2:0] OFF_DATA    = 3'd0;
  localparam logic [2:0] OFF_STATUS  = 3'd1;
  localparam logic [2:0] OFF_CONTROL = 3'd2;

  localparam logic [7:0] ST_BUSY   = 8'h80;
  localparam logic [7:0] ST_ACK    = 8'h40;
  localparam logic [7:0] ST_ONLINE = 8'h10;
  localparam logic [7:0] ST_ERROR  = 8'h08;
  localparam logic [7:0] ST_TMOUT  = 8'h01;

  localparam logic [7:0] CT_FIXED  = 8'hC0;
  localparam logic [7:0] CT_DIR    = 8'h20;
  localparam logic [7:0] CT_INTEN  = 8'h10;
  localparam logic [7:0] CT_SELECT = 8'h08;
  localparam logic [7:0] CT_INIT   = 8'h04;
  localparam logic [7:0] CT_STROBE = 8'h01;

  localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;
  localparam logic [7:0] INPUT_LATCH   = 8'hFF;
  localparam logic [7:0] DATA_RESET    = 8'hFF;
  localparam logic [7:0] STATUS_RESET  = ST_BUSY | ST_ACK | ST_ONLINE | ST_ERROR | ST_TMOUT;
  localparam logic [7:0] STATUS_INIT   = ST_BUSY | ST_ACK | ST_ONLINE | ST_ERROR;
  localparam logic [7:0] CONTROL_RESET = CT_FIXED | CT_SELECT | CT_INIT;

endpackage

`default_nettype wire

### sv/ppp_regs.sv
// Register file of the printer port: data latch, status, control, pending interrupt.
// Decodes one bus access per fire and forms its result word. Uses ppp_pkg.
`default_nettype none

module ppp_regs import ppp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  ppp_in_t  item_i,
  output ppp_out_t result_o
);

  logic [7:0] data_q, data_d;
  logic [7:0] status_q, status_d;
  logic [7:0] ctrl_q, ctrl_d;
  logic       irq_q, irq_d;
  logic [7:0] nv;
  ppp_out_t   res;

  always_comb begin
    data_d   = data_q;
    status_d = status_q;
    ctrl_d   = ctrl_q;
    irq_d    = irq_q;
    nv       = item_i.write_data | CT_FIXED;
    res      = '0;
    if (item_i.cmd == CMD_WRITE) begin
      if (item_i.reg_offset == OFF_DATA) begin
        data_d = item_i.write_data;
      end else if (item_i.reg_offset == OFF_CONTROL) begin
        if ((nv & CT_INIT) == '0) begin
          status_d = STATUS_INIT;
        end else if ((nv & CT_SELECT) != '0) begin
          if ((nv & CT_STROBE) != '0) begin
            status_d = status_q & ~ST_BUSY;
            if ((ctrl_q & CT_STROBE) == '0) begin
              res.printer_byte_valid = 1'b1;
              res.printer_byte       = data_q;
            end
          end else if ((ctrl_q & CT_INTEN) != '0) begin
            irq_d = 1'b1;
          end
        end
        ctrl_d = nv;
      end
    end else begin
      res.read_data = BYTE_ALL_ONES;
      if (item_i.reg_offset == OFF_DATA) begin
        res.read_data = ((ctrl_q & CT_DIR) != '0) ? INPUT_LATCH : data_q;
      end else if (item_i.reg_offset == OFF_STATUS) begin
        res.read_data = status_q;
        irq_d = 1'b0;
        if ((status_q & ST_BUSY) == '0 && (ctrl_q & CT_STROBE) == '0) begin
          if ((status_q & ST_ACK) != '0) begin
            status_d = status_q & ~ST_ACK;
          end else begin
            status_d = status_q | ST_ACK | ST_BUSY;
          end
        end
      end else if (item_i.reg_offset == OFF_CONTROL) begin
        res.read_data = ctrl_q;
      end
    end
    res.irq_line = irq_d;
  end

  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q   <= DATA_RESET;
      status_q <= STATUS_RESET;
      ctrl_q   <= CONTROL_RESET;
      irq_q    <= 1'b0;
    end else if (fire_i) begin
      data_q   <= data_d;
      status_q <= status_d;
      ctrl_q   <= ctrl_d;
      irq_q    <= irq_d;
    end
  end

`ifndef SYNTHESIS
  a_ctrl_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q[7:6] == 2'b11)
    else $error("control bits 7:6 not set");

  a_status_read_clears_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.cmd == CMD_READ && item_i.reg_offset == OFF_STATUS |=> !irq_q)
    else $error("status read left interrupt pending");

  a_send_leaves_strobe_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.printer_byte_valid |=>
      (ctrl_q & CT_STROBE) != '0 && (status_q & ST_BUSY) == '0)
    else $error("byte sent without strobe high and busy clear");

  a_init_low_resets_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.cmd == CMD_WRITE && item_i.reg_offset == OFF_CONTROL &&
      !item_i.write_data[2] |=> status_q == STATUS_INIT)
    else $error("init low did not force ready status");
`endif

endmodule

`default_nettype wire

### sv/parallel_printer_port_core.sv
// An accepted word waits in the input register; its result goes to the result register.
// Throughput: one word per cycle unless the output stalls, which stalls the input too.
// Reset (rst_ni low, asynchronous): data 0xFF, status 0xD9, control 0xCC,
// no interrupt pending, both pipeline registers empty.
// Top level of the parallel printer port core. Uses ppp_pkg and ppp_regs.
`default_nettype none

module parallel_printer_port_core import ppp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ppp_in_t  in_word_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ppp_out_t out_word_o
);

  logic     s1_valid_q, s1_valid_d;
  ppp_in_t  s1_word_q;
  logic     out_valid_q;
  ppp_out_t out_word_q;
  ppp_out_t result;
  logic     out_ready;
  logic     fire;
  logic     in_accept;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (fire) begin
      s1_valid_d = 1'b0;
    end
  end

  ppp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .item_i  (s1_word_q),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_word_q <= in_word_i;
    end
    if (fire) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire
